// ----- rtl/core/semantic_grid_cost_overlay_assert.svh -----
// Assertion macros for the semantic grid cost overlay checkers.
// No dependencies; included by the checker file.
`ifndef SEMANTIC_GRID_COST_OVERLAY_ASSERT_SVH
`define SEMANTIC_GRID_COST_OVERLAY_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define SGCO_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("sgco assertion failed");

// consequent checked in the cycle after the antecedent
`define SGCO_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("sgco assertion failed");

`endif

// ----- rtl/core/sgco_pkg.sv -----
// Shared types and constants for the semantic grid cost overlay.
// No dependencies; used by the top level and the testbench.
package sgco_pkg;

  localparam int unsigned GRID_ENTRIES = 65536;
  localparam int unsigned COSTMAP_SIDE = 1024;
  localparam int unsigned FRAC_BITS    = 16;

  localparam int unsigned CELL_W  = $clog2(COSTMAP_SIDE);
  localparam int unsigned IDX_W   = 16;
  localparam int unsigned CLS_W   = 2;
  localparam int unsigned COST_W  = 8;
  localparam int unsigned CFG_W   = 32;
  localparam int unsigned DIM_W   = 9;
  localparam int unsigned CNT_W   = 21;
  localparam int unsigned CIDX_W  = 3;
  localparam int unsigned ADDR_W  = $clog2(GRID_ENTRIES);
  localparam int unsigned PROD_W  = CFG_W + CELL_W + 1;
  localparam int unsigned Q_W     = PROD_W + 2;
  localparam int unsigned HI_W    = Q_W - FRAC_BITS;
  localparam int unsigned AT_W    = 2 * DIM_W + 1;

  localparam int unsigned S_TDATA_W = 48;
  localparam int unsigned M_TDATA_W = 32;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  typedef enum logic [CIDX_W-1:0] {
    REG_ROT_COS      = 3'd0,
    REG_ROT_SIN      = 3'd1,
    REG_OFFSET_X     = 3'd2,
    REG_OFFSET_Y     = 3'd3,
    REG_GRID_WIDTH   = 3'd4,
    REG_GRID_HEIGHT  = 3'd5,
    REG_CROSS_COST   = 3'd6,
    REG_NONDRV_COST  = 3'd7
  } cfg_reg_e;

  typedef enum logic [CLS_W-1:0] {
    CLS_DRIVABLE     = 2'd0,
    CLS_NON_DRIVABLE = 2'd1,
    CLS_CROSSWALK    = 2'd2,
    CLS_UNKNOWN      = 2'd3
  } class_e;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_CELL = 1'b1
  } opcode_e;

  // per-beat control that rides along the pipeline
  typedef struct packed {
    opcode_e                  op;
    logic                     last;
    logic signed [COST_W-1:0] cur;
    logic [IDX_W-1:0]         gidx;
    logic [CLS_W-1:0]         gcls;
  } item_ctl_t;

endpackage

// ----- rtl/core/sgco_ram.sv -----
// Generic single-port synchronous RAM with registered read.
// No dependencies; holds the class store of the overlay block.
module sgco_ram #(
  parameter int unsigned Width = 2,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/semantic_grid_cost_overlay.sv -----
// Semantic grid cost overlay top level.
// Depends on sgco_pkg and sgco_ram.
//
// Takes one beat per clock while the pipeline advances and returns one result beat per
// input beat, in order. The whole pipeline advances together whenever the output
// register is empty or being drained, so throughput is one beat per cycle. The class
// store is a single-port RAM touched by at most one beat per cycle in the address stage
// (load beats write, cell beats read), so loads and later cells never collide. Stages:
// rotation products, signed Q29.16 sums, truncation and bounds, row-major index, store
// read, output register. Configuration writes are taken at any time but must only
// happen while the pipeline is empty.
module semantic_grid_cost_overlay (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // grid_index, grid_class, cell_x, cell_y, current_cost, zero pad
  input  logic [sgco_pkg::S_TDATA_W-1:0]      s_axis_tdata,
  input  logic                                s_axis_tuser,   // opcode
  input  logic                                s_axis_tlast,   // last_cell
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // new_cost, raised, raised_count, grid_ready, zero pad
  output logic [sgco_pkg::M_TDATA_W-1:0]      m_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [sgco_pkg::CIDX_W-1:0]         cfg_index_i,
  input  logic [sgco_pkg::CFG_W-1:0]          cfg_data_i
);

  // configuration
  logic signed [sgco_pkg::CFG_W-1:0]  rot_cos_q, rot_sin_q, off_x_q, off_y_q;
  logic [sgco_pkg::DIM_W-1:0]         grid_w_q, grid_h_q;
  logic signed [sgco_pkg::COST_W-1:0] cross_cost_q, nondrv_cost_q;
  logic                               grid_ready;

  assign cfg_ready_o = 1'b1;
  assign grid_ready  = (grid_w_q != '0) && (grid_h_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_cos_q     <= '0;
      rot_sin_q     <= '0;
      off_x_q       <= '0;
      off_y_q       <= '0;
      grid_w_q      <= '0;
      grid_h_q      <= '0;
      cross_cost_q  <= '0;
      nondrv_cost_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (sgco_pkg::cfg_reg_e'(cfg_index_i))
        sgco_pkg::REG_ROT_COS:     rot_cos_q     <= cfg_data_i;
        sgco_pkg::REG_ROT_SIN:     rot_sin_q     <= cfg_data_i;
        sgco_pkg::REG_OFFSET_X:    off_x_q       <= cfg_data_i;
        sgco_pkg::REG_OFFSET_Y:    off_y_q       <= cfg_data_i;
        sgco_pkg::REG_GRID_WIDTH:  grid_w_q      <= cfg_data_i[sgco_pkg::DIM_W-1:0];
        sgco_pkg::REG_GRID_HEIGHT: grid_h_q      <= cfg_data_i[sgco_pkg::DIM_W-1:0];
        sgco_pkg::REG_CROSS_COST:  cross_cost_q  <= cfg_data_i[sgco_pkg::COST_W-1:0];
        sgco_pkg::REG_NONDRV_COST: nondrv_cost_q <= cfg_data_i[sgco_pkg::COST_W-1:0];
        default: ;
      endcase
    end
  end

  // flow control
  logic advance, out_valid_q;
  logic v1_q, v2_q, v3_q, v4_q, v5_q;

  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      v5_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      v1_q        <= s_axis_tvalid;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      v4_q        <= v3_q;
      v5_q        <= v4_q;
      out_valid_q <= v5_q;
    end
  end

  // stage 1: rotation products
  sgco_pkg::item_ctl_t                 ctl_d, ctl1_q, ctl2_q, ctl3_q, ctl4_q, ctl5_q;
  logic signed [sgco_pkg::CELL_W:0]    cx_s, cy_s;
  logic signed [sgco_pkg::PROD_W-1:0]  pa_d, pb_d, pc_d, pd_d, pa_q, pb_q, pc_q, pd_q;

  assign ctl_d.gidx = s_axis_tdata[15:0];
  assign ctl_d.gcls = s_axis_tdata[17:16];
  assign cx_s       = $signed({1'b0, s_axis_tdata[27:18]});
  assign cy_s       = $signed({1'b0, s_axis_tdata[37:28]});
  assign ctl_d.cur  = s_axis_tdata[45:38];
  assign ctl_d.op   = sgco_pkg::opcode_e'(s_axis_tuser);
  assign ctl_d.last = s_axis_tlast;

  assign pa_d = rot_cos_q * cx_s;
  assign pb_d = rot_sin_q * cy_s;
  assign pc_d = rot_sin_q * cx_s;
  assign pd_d = rot_cos_q * cy_s;

  // stage 2: fixed-point sums
  logic signed [sgco_pkg::Q_W-1:0] qx_d, qy_d, qx_q, qy_q;

  assign qx_d = pa_q - pb_q + off_x_q;
  assign qy_d = pc_q + pd_q + off_y_q;

  // stage 3: truncate toward zero and bound; a negative value above -1.0 lands on zero
  logic [sgco_pkg::HI_W-1:0]  x_hi, y_hi;
  logic                       x_in, y_in, inside_d, inside3_q, inside4_q;
  logic [sgco_pkg::DIM_W-1:0] gx_d, gy_d, gx_q, gy_q;

  assign x_hi = qx_q[sgco_pkg::Q_W-1:sgco_pkg::FRAC_BITS];
  assign y_hi = qy_q[sgco_pkg::Q_W-1:sgco_pkg::FRAC_BITS];
  assign x_in = qx_q[sgco_pkg::Q_W-1] ? ((&x_hi) && (|qx_q[sgco_pkg::FRAC_BITS-1:0]))
                                      : (x_hi < sgco_pkg::HI_W'(grid_w_q));
  assign y_in = qy_q[sgco_pkg::Q_W-1] ? ((&y_hi) && (|qy_q[sgco_pkg::FRAC_BITS-1:0]))
                                      : (y_hi < sgco_pkg::HI_W'(grid_h_q));
  assign gx_d = qx_q[sgco_pkg::Q_W-1] ? '0
              : qx_q[sgco_pkg::FRAC_BITS+sgco_pkg::DIM_W-1:sgco_pkg::FRAC_BITS];
  assign gy_d = qy_q[sgco_pkg::Q_W-1] ? '0
              : qy_q[sgco_pkg::FRAC_BITS+sgco_pkg::DIM_W-1:sgco_pkg::FRAC_BITS];
  assign inside_d = grid_ready && x_in && y_in;

  // stage 4: row-major index, store access
  logic [sgco_pkg::AT_W-1:0]   at_d, at_q;
  logic                        hit_d, hit_q;
  logic                        ram_en, ram_we;
  logic [sgco_pkg::ADDR_W-1:0] ram_addr;
  logic [sgco_pkg::CLS_W-1:0]  ram_rdata;

  assign at_d  = sgco_pkg::AT_W'(gy_q) * sgco_pkg::AT_W'(grid_w_q) + sgco_pkg::AT_W'(gx_q);
  assign hit_d = inside4_q && (32'(at_q) < sgco_pkg::GRID_ENTRIES);

  assign ram_en   = advance && v4_q;
  assign ram_we   = (ctl4_q.op == sgco_pkg::OP_LOAD) &&
                    (32'(ctl4_q.gidx) < sgco_pkg::GRID_ENTRIES);
  assign ram_addr = (ctl4_q.op == sgco_pkg::OP_LOAD) ? sgco_pkg::ADDR_W'(ctl4_q.gidx)
                                                     : sgco_pkg::ADDR_W'(at_q);

  sgco_ram #(
    .Width (sgco_pkg::CLS_W),
    .Depth (sgco_pkg::GRID_ENTRIES)
  ) u_class_store (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ctl4_q.gcls),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (advance) begin
      ctl1_q    <= ctl_d;
      pa_q      <= pa_d;
      pb_q      <= pb_d;
      pc_q      <= pc_d;
      pd_q      <= pd_d;
      ctl2_q    <= ctl1_q;
      qx_q      <= qx_d;
      qy_q      <= qy_d;
      ctl3_q    <= ctl2_q;
      gx_q      <= gx_d;
      gy_q      <= gy_d;
      inside3_q <= inside_d;
      ctl4_q    <= ctl3_q;
      at_q      <= at_d;
      inside4_q <= inside3_q;
      ctl5_q    <= ctl4_q;
      hit_q     <= hit_d;
    end
  end

  // stage 5: cost selection and raise counter
  logic signed [sgco_pkg::COST_W-1:0] add_cost, new_cost_d, new_cost_q;
  logic                               is_cell, raise_d, raised_q, ready_q;
  logic [sgco_pkg::CNT_W-1:0]         cnt_q, cnt_inc, cnt_d, count_q;

  always_comb begin
    case (sgco_pkg::class_e'(ram_rdata))
      sgco_pkg::CLS_NON_DRIVABLE: add_cost = nondrv_cost_q;
      sgco_pkg::CLS_CROSSWALK:    add_cost = cross_cost_q;
      default:                    add_cost = '0;
    endcase
  end

  assign is_cell    = (ctl5_q.op == sgco_pkg::OP_CELL);
  assign raise_d    = is_cell && hit_q && (add_cost > 0) &&
                      ((ctl5_q.cur == -8'sd1) || (add_cost > ctl5_q.cur));
  assign new_cost_d = raise_d ? add_cost : (is_cell ? ctl5_q.cur : '0);
  assign cnt_inc    = (raise_d && (cnt_q != sgco_pkg::CNT_MAX)) ? cnt_q + 1'b1 : cnt_q;
  assign cnt_d      = (is_cell && ctl5_q.last) ? '0 : cnt_inc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (advance && v5_q) begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      new_cost_q <= new_cost_d;
      raised_q   <= raise_d;
      count_q    <= cnt_inc;
      ready_q    <= grid_ready;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, ready_q, count_q, raised_q, new_cost_q};

endmodule

// ----- rtl/core/sgco_checker.sv -----
// Port-level checker for the semantic grid cost overlay, bound to the top level.
// Depends on semantic_grid_cost_overlay_assert.svh and semantic_grid_cost_overlay.
`include "semantic_grid_cost_overlay_assert.svh"

module sgco_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);

  // a stalled result beat holds
  `SGCO_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

  // a raised cell carries a positive cost, a nonzero count and a ready grid
  `SGCO_ASSERT_NOW(a_raise_sane, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata[8], !m_axis_tdata[7] && (m_axis_tdata[7:0] != 8'd0) && (m_axis_tdata[29:9] != 21'd0) && m_axis_tdata[30])

  // a stalled output backs up the input side
  `SGCO_ASSERT_NOW(a_backpressure, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, !s_axis_tready)

endmodule

bind semantic_grid_cost_overlay sgco_checker u_sgco_checker (.*);

// ----- verif/tb_semantic_grid_cost_overlay.sv -----
// Testbench for semantic_grid_cost_overlay: grid loads and costmap cell beats, directed and
// random, with random stalls on both streams, checked beat by beat against an in-bench model.
// Depends on sgco_pkg and the RTL of the block.
module tb_semantic_grid_cost_overlay;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     PIPE_DEPTH  = 6;
  localparam int     STUCK_LIMIT = 2000;
  localparam int     MAX_PRINTS  = 50;
  localparam longint Q_ONE       = longint'(1) << sgco_pkg::FRAC_BITS;

  typedef struct {
    sgco_pkg::opcode_e                  op;
    logic [sgco_pkg::IDX_W-1:0]         gidx;
    logic [sgco_pkg::CLS_W-1:0]         gcls;
    logic [sgco_pkg::CELL_W-1:0]        cx;
    logic [sgco_pkg::CELL_W-1:0]        cy;
    logic signed [sgco_pkg::COST_W-1:0] cost;
    logic                               last;
  } overlay_in_t;

  typedef struct {
    logic signed [sgco_pkg::COST_W-1:0] new_cost;
    logic                               raised;
    logic [sgco_pkg::CNT_W-1:0]         count;
    logic                               ready;
  } overlay_out_t;

  logic                             clk_i = 1'b0;
  logic                             rst_ni;
  logic [sgco_pkg::S_TDATA_W-1:0]   s_axis_tdata;
  logic                             s_axis_tuser;
  logic                             s_axis_tlast;
  logic                             s_axis_tvalid;
  logic                             s_axis_tready;
  logic [sgco_pkg::M_TDATA_W-1:0]   m_axis_tdata;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready;
  logic                             cfg_valid_i;
  logic                             cfg_ready_o;
  logic [sgco_pkg::CIDX_W-1:0]      cfg_index_i;
  logic [sgco_pkg::CFG_W-1:0]       cfg_data_i;

  // register copies
  int rot_cos_q   = 0;
  int rot_sin_q   = 0;
  int off_x_q     = 0;
  int off_y_q     = 0;
  int grid_w      = 0;
  int grid_h      = 0;
  int cross_cost  = 0;
  int nondrv_cost = 0;

  logic [sgco_pkg::CLS_W-1:0] class_copy    [sgco_pkg::GRID_ENTRIES];
  bit                         store_written [sgco_pkg::GRID_ENTRIES];
  logic [sgco_pkg::CNT_W-1:0] raised_cells = '0;

  overlay_out_t expected_costs_q [$];
  overlay_out_t head_r;

  int error_count     = 0;
  int stuck_cycles    = 0;
  int hold_off_cycles = 0;
  bit tx_idle         = 1'b0;
  bit rx_idle         = 1'b0;

  semantic_grid_cost_overlay i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  function automatic overlay_in_t make_load(input logic [sgco_pkg::IDX_W-1:0] idx,
                                            input sgco_pkg::class_e cls);
    overlay_in_t it;
    it.op   = sgco_pkg::OP_LOAD;
    it.gidx = idx;
    it.gcls = cls;
    it.cx   = sgco_pkg::CELL_W'($urandom);
    it.cy   = sgco_pkg::CELL_W'($urandom);
    it.cost = sgco_pkg::COST_W'($urandom);
    it.last = 1'b0;
    return it;
  endfunction

  function automatic overlay_in_t make_cell(input logic [sgco_pkg::CELL_W-1:0] x, y,
                                            input logic signed [sgco_pkg::COST_W-1:0] cost,
                                            input bit last);
    overlay_in_t it;
    it.op   = sgco_pkg::OP_CELL;
    it.gidx = sgco_pkg::IDX_W'($urandom);
    it.gcls = sgco_pkg::CLS_W'($urandom);
    it.cx   = x;
    it.cy   = y;
    it.cost = cost;
    it.last = last;
    return it;
  endfunction

  function automatic logic signed [sgco_pkg::COST_W-1:0] random_cost();
    if ($urandom_range(0, 3) == 0) return -1;
    return sgco_pkg::COST_W'($urandom);
  endfunction

  // Maps a costmap cell onto the grid; returns 1 with the row-major address when inside.
  function automatic bit locate_cell(input logic [sgco_pkg::CELL_W-1:0] cx, cy,
                                     output int unsigned addr);
    longint qx, qy, gx, gy;
    addr = 0;
    if (grid_w == 0 || grid_h == 0) return 1'b0;
    qx = longint'(rot_cos_q) * longint'(cx) - longint'(rot_sin_q) * longint'(cy)
         + longint'(off_x_q);
    qy = longint'(rot_sin_q) * longint'(cx) + longint'(rot_cos_q) * longint'(cy)
         + longint'(off_y_q);
    gx = qx / Q_ONE;  // division truncates toward zero
    gy = qy / Q_ONE;
    if (gx < 0 || gy < 0 || gx >= grid_w || gy >= grid_h) return 1'b0;
    addr = gy * grid_w + gx;
    return addr < sgco_pkg::GRID_ENTRIES;
  endfunction

  function automatic void predict_overlay(input overlay_in_t it);
    overlay_out_t r;
    int unsigned  addr;
    int           add;
    int           cur;
    cur      = int'(it.cost);
    r.ready  = (grid_w != 0) && (grid_h != 0);
    r.raised = 1'b0;
    if (it.op == sgco_pkg::OP_LOAD) begin
      class_copy[it.gidx]    = it.gcls;
      store_written[it.gidx] = 1'b1;
      r.new_cost             = '0;
    end else begin
      r.new_cost = it.cost;
      if (locate_cell(it.cx, it.cy, addr)) begin
        case (sgco_pkg::class_e'(class_copy[addr]))
          sgco_pkg::CLS_NON_DRIVABLE: add = nondrv_cost;
          sgco_pkg::CLS_CROSSWALK:    add = cross_cost;
          default:                    add = 0;
        endcase
        if (add > 0 && (cur == -1 || add > cur)) begin
          r.new_cost = add[sgco_pkg::COST_W-1:0];
          r.raised   = 1'b1;
          if (raised_cells != sgco_pkg::CNT_MAX) raised_cells++;
        end
      end
    end
    r.count = raised_cells;
    if (it.op == sgco_pkg::OP_CELL && it.last) raised_cells = '0;
    expected_costs_q.push_back(r);
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (error_count < MAX_PRINTS)
      $display("%0t mismatch %s: got %0h expected %0h", $time, what, got, want);
    error_count++;
  endtask

  task automatic offer_beat(input overlay_in_t it);
    int gap;
    gap = tx_idle ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.op;
    s_axis_tlast  <= it.last;
    s_axis_tdata  <= {2'b00, it.cost, it.cy, it.cx, it.gcls, it.gidx};
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    predict_overlay(it);
  endtask

  // A cell that would read a never-written grid entry gets that entry loaded first.
  task automatic send_item(input overlay_in_t it);
    int unsigned addr;
    if (it.op == sgco_pkg::OP_CELL && locate_cell(it.cx, it.cy, addr) && !store_written[addr])
      offer_beat(make_load(addr[sgco_pkg::IDX_W-1:0],
                           sgco_pkg::class_e'($urandom_range(0, 3))));
    offer_beat(it);
  endtask

  task automatic wait_results_done();
    s_axis_tvalid <= 1'b0;
    while (expected_costs_q.size() != 0) @(posedge clk_i);
    repeat (PIPE_DEPTH + 4) @(posedge clk_i);
  endtask

  task automatic program_overlay_regs(input int rc, rs, ox, oy, w, h, xwalk, nondrv);
    logic [sgco_pkg::CFG_W-1:0] vals [2**sgco_pkg::CIDX_W];
    sgco_pkg::cfg_reg_e         r;
    vals[sgco_pkg::REG_ROT_COS]     = rc;
    vals[sgco_pkg::REG_ROT_SIN]     = rs;
    vals[sgco_pkg::REG_OFFSET_X]    = ox;
    vals[sgco_pkg::REG_OFFSET_Y]    = oy;
    vals[sgco_pkg::REG_GRID_WIDTH]  = w;
    vals[sgco_pkg::REG_GRID_HEIGHT] = h;
    vals[sgco_pkg::REG_CROSS_COST]  = xwalk;
    vals[sgco_pkg::REG_NONDRV_COST] = nondrv;
    wait_results_done();
    r = r.first();
    do begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= r;
      cfg_data_i  <= vals[r];
      do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
      case (r)
        sgco_pkg::REG_ROT_COS:     rot_cos_q   = int'(vals[r]);
        sgco_pkg::REG_ROT_SIN:     rot_sin_q   = int'(vals[r]);
        sgco_pkg::REG_OFFSET_X:    off_x_q     = int'(vals[r]);
        sgco_pkg::REG_OFFSET_Y:    off_y_q     = int'(vals[r]);
        sgco_pkg::REG_GRID_WIDTH:  grid_w      = int'(vals[r][sgco_pkg::DIM_W-1:0]);
        sgco_pkg::REG_GRID_HEIGHT: grid_h      = int'(vals[r][sgco_pkg::DIM_W-1:0]);
        sgco_pkg::REG_CROSS_COST:
          cross_cost  = int'($signed(vals[r][sgco_pkg::COST_W-1:0]));
        sgco_pkg::REG_NONDRV_COST:
          nondrv_cost = int'($signed(vals[r][sgco_pkg::COST_W-1:0]));
        default: ;
      endcase
      r = r.next();
    end while (r != r.first());
    cfg_valid_i <= 1'b0;
  endtask

  // Registers still at reset: no grid, every cell passes through; then one dimension zero.
  task automatic test_no_grid();
    overlay_in_t it;
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    it = make_load(16'h0000, sgco_pkg::CLS_NON_DRIVABLE);
    it.last = 1'b1;
    send_item(it);
    send_item(make_load(16'hFFFF, sgco_pkg::CLS_CROSSWALK));
    send_item(make_load(16'h5555, sgco_pkg::CLS_UNKNOWN));
    send_item(make_load(16'hAAAA, sgco_pkg::CLS_DRIVABLE));
    send_item(make_cell(10'd0, 10'd0, -8'sd1, 1'b0));
    send_item(make_cell(10'h3FF, 10'h3FF, 8'sd127, 1'b0));
    send_item(make_cell(10'h155, 10'h2AA, -8'sd128, 1'b1));
    program_overlay_regs(Q_ONE, 0, 0, 0, 0, 256, 127, 127);
    send_item(make_cell(10'd0, 10'd0, -8'sd1, 1'b0));
    send_item(make_cell(10'd5, 10'd5, -8'sd1, 1'b0));
    program_overlay_regs(Q_ONE, 0, 0, 0, 256, 0, 127, 127);
    send_item(make_cell(10'd5, 10'd5, -8'sd1, 1'b1));
  endtask

  // Identity mapping on a 16x16 grid: every class, cost comparisons, bounds, pass end.
  task automatic test_class_costs();
    program_overlay_regs(Q_ONE, 0, 0, 0, 16, 16, 50, 100);
    send_item(make_load(16'd0, sgco_pkg::CLS_NON_DRIVABLE));
    send_item(make_load(16'd1, sgco_pkg::CLS_CROSSWALK));
    send_item(make_load(16'd2, sgco_pkg::CLS_DRIVABLE));
    send_item(make_load(16'd3, sgco_pkg::CLS_UNKNOWN));
    send_item(make_load(16'd17, sgco_pkg::CLS_NON_DRIVABLE));
    send_item(make_cell(10'd0, 10'd0, -8'sd1, 1'b0));
    send_item(make_cell(10'd0, 10'd0, 8'sd100, 1'b0));
    send_item(make_cell(10'd0, 10'd0, 8'sd99, 1'b0));
    send_item(make_cell(10'd1, 10'd0, -8'sd128, 1'b0));
    send_item(make_cell(10'd1, 10'd0, 8'sd127, 1'b0));
    send_item(make_cell(10'd2, 10'd0, -8'sd1, 1'b0));
    send_item(make_cell(10'd3, 10'd0, -8'sd1, 1'b0));
    send_item(make_cell(10'd16, 10'd0, -8'sd1, 1'b0));
    send_item(make_cell(10'd0, 10'd16, -8'sd1, 1'b0));
    send_item(make_cell(10'h3FF, 10'h3FF, -8'sd1, 1'b0));
    send_item(make_cell(10'd1, 10'd1, 8'sd5, 1'b1));
    send_item(make_cell(10'd1, 10'd1, -8'sd1, 1'b0));
  endtask

  // Negative half-cell offset: coordinates just below zero truncate to zero, not -1.
  task automatic test_truncation_and_bounds();
    program_overlay_regs(Q_ONE, 0, -(Q_ONE / 2), -2 * Q_ONE, 256, 256, 127, -128);
    send_item(make_load(16'd768, sgco_pkg::CLS_CROSSWALK));
    send_item(make_load(16'd0, sgco_pkg::CLS_NON_DRIVABLE));
    send_item(make_cell(10'd0, 10'd5, -8'sd1, 1'b0));
    send_item(make_cell(10'd1, 10'd5, -8'sd1, 1'b0));
    send_item(make_cell(10'd0, 10'd1, -8'sd1, 1'b0));
    send_item(make_cell(10'd0, 10'd2, -8'sd1, 1'b0));
    send_item(make_cell(10'h3FF, 10'd257, -8'sd1, 1'b1));
  endtask

  task automatic test_register_extremes();
    program_overlay_regs(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                         256, 1, 127, 127);
    send_item(make_cell(10'd0, 10'd0, -8'sd1, 1'b0));
    send_item(make_cell(10'd0, 10'd1, -8'sd1, 1'b0));
    send_item(make_cell(10'h3FF, 10'd0, -8'sd1, 1'b0));
    for (int i = 0; i < 4; i++)
      send_item(make_cell(sgco_pkg::CELL_W'($urandom), sgco_pkg::CELL_W'($urandom),
                          random_cost(), 1'b0));
    // zero rotation: every cell lands on one entry
    program_overlay_regs(0, 0, 5 * Q_ONE, 7 * Q_ONE, 256, 256, -128, 127);
    for (int i = 0; i < 6; i++)
      send_item(make_cell(sgco_pkg::CELL_W'($urandom), sgco_pkg::CELL_W'($urandom),
                          random_cost(), i == 5));
  endtask

  task automatic test_random_passes(input int phases, input int items_per_phase);
    int sent, kind, len, scale, span, w, h;
    int rc, rs, ox, oy, xwalk, nondrv;
    logic [sgco_pkg::CELL_W-1:0] x, y;
    logic [sgco_pkg::IDX_W-1:0]  idx;
    for (int p = 0; p < phases; p++) begin
      w = $urandom_range(1, 256);
      h = $urandom_range(1, 256);
      if ($urandom_range(0, 7) == 0) begin
        if ($urandom_range(0, 1)) w = 0;
        else h = 0;
      end
      if ($urandom_range(0, 5) == 0) begin
        rc = $urandom;
        rs = $urandom;
        ox = $urandom;
        oy = $urandom;
      end else begin
        scale = $urandom_range(8192, 98304);
        rc = $urandom_range(0, scale);
        rs = $urandom_range(0, scale / 2);
        if ($urandom_range(0, 3) == 0) rc = -rc;
        if ($urandom_range(0, 1)) rs = -rs;
        ox = (int'($urandom_range(0, 300)) - 40) * Q_ONE + int'($urandom_range(0, 65535));
        oy = (int'($urandom_range(0, 300)) - 40) * Q_ONE + int'($urandom_range(0, 65535));
      end
      xwalk  = ($urandom_range(0, 9) == 0) ? -128 : int'($urandom_range(0, 191)) - 64;
      nondrv = ($urandom_range(0, 9) == 0) ? 127 : int'($urandom_range(0, 191)) - 64;
      program_overlay_regs(rc, rs, ox, oy, w, h, xwalk, nondrv);
      tx_idle = $urandom_range(0, 3) != 0;
      rx_idle = $urandom_range(0, 3) != 0;
      span    = $urandom_range(0, 1) ? 1023 : 255;
      sent    = 0;
      while (sent < items_per_phase) begin
        kind = $urandom_range(0, 99);
        if (kind < 15) begin
          if (w * h > 0 && $urandom_range(0, 1)) idx = $urandom_range(0, w * h - 1);
          else idx = sgco_pkg::IDX_W'($urandom);
          send_item(make_load(idx, sgco_pkg::class_e'($urandom_range(0, 3))));
          sent++;
        end else if (kind < 25) begin
          send_item(make_cell(sgco_pkg::CELL_W'($urandom), sgco_pkg::CELL_W'($urandom),
                              random_cost(), $urandom_range(0, 1)));
          sent++;
        end else begin
          len = $urandom_range(4, 40);
          x   = $urandom_range(0, span);
          y   = $urandom_range(0, span);
          for (int i = 0; i < len; i++) begin
            send_item(make_cell(x, y, random_cost(), i == len - 1));
            if (x >= span) begin
              x = '0;
              y++;
            end else begin
              x++;
            end
          end
          sent += len;
        end
      end
    end
  endtask

  // Receiver holds off while the sender keeps offering, then the sender waits for all results.
  task automatic test_backpressure();
    program_overlay_regs(0, 0, 3 * Q_ONE, 3 * Q_ONE, 16, 16, 90, 60);
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    hold_off_cycles = 120;
    for (int i = 0; i < 48; i++)
      send_item(make_cell(sgco_pkg::CELL_W'(i), 10'd9, random_cost(), i == 47));
    wait_results_done();
  endtask

  // result sink
  initial begin
    m_axis_tready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_off_cycles > 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold_off_cycles) @(posedge clk_i);
        hold_off_cycles = 0;
      end else begin
        automatic int wait_cycles = rx_idle ? $urandom_range(0, 14) : 0;
        if (wait_cycles > 0) begin
          m_axis_tready <= 1'b0;
          repeat (wait_cycles) @(posedge clk_i);
        end
        m_axis_tready <= 1'b1;
        do @(posedge clk_i); while (m_axis_tvalid !== 1'b1);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_costs_q.size() == 0) begin
        report_mismatch("result beat with nothing outstanding", m_axis_tdata, 0);
      end else begin
        head_r = expected_costs_q.pop_front();
        if (m_axis_tdata[sgco_pkg::COST_W-1:0] !== head_r.new_cost)
          report_mismatch("new_cost", m_axis_tdata[sgco_pkg::COST_W-1:0], head_r.new_cost);
        if (m_axis_tdata[sgco_pkg::COST_W] !== head_r.raised)
          report_mismatch("raised", m_axis_tdata[sgco_pkg::COST_W], head_r.raised);
        if (m_axis_tdata[sgco_pkg::COST_W+1 +: sgco_pkg::CNT_W] !== head_r.count)
          report_mismatch("raised_count", m_axis_tdata[sgco_pkg::COST_W+1 +: sgco_pkg::CNT_W],
                          head_r.count);
        if (m_axis_tdata[sgco_pkg::COST_W+1+sgco_pkg::CNT_W] !== head_r.ready)
          report_mismatch("grid_ready", m_axis_tdata[sgco_pkg::COST_W+1+sgco_pkg::CNT_W],
                          head_r.ready);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("semantic_grid_cost_overlay test failed");
      $finish;
    end
  end

  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= sgco_pkg::OP_LOAD;
    s_axis_tlast  <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= sgco_pkg::REG_ROT_COS;
    cfg_data_i    <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_no_grid();
    test_class_costs();
    test_truncation_and_bounds();
    test_register_extremes();
    test_random_passes(9, 95);
    test_backpressure();
    wait_results_done();
    if (error_count == 0)
      $display("semantic_grid_cost_overlay test passed");
    else
      $display("semantic_grid_cost_overlay test failed");
    $finish;
  end

endmodule
